// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define THIST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define THIST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: design/thist_pkg.sv
`default_nettype none
package thist_pkg;

  // sizing
  localparam int GRID_MAX    = 8;
  localparam int COUNT_WIDTH = 24;
  localparam int COORD_WIDTH = 12;

  localparam int PIX_W     = 8;
  localparam int NBINS     = 256;
  localparam int TW_W      = 12;
  localparam int GC_W      = 4;
  localparam int CLIP_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int NTILES   = GRID_MAX * GRID_MAX;
  localparam int TILE_W   = (NTILES > 1) ? $clog2(NTILES) : 1;
  localparam int POS_W    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int GCNT_W   = $clog2(GRID_MAX + 1);
  localparam int ADDR_W   = TILE_W + PIX_W;
  localparam int NENTRIES = NTILES * NBINS;

  // build arithmetic widths
  localparam int H_W    = (COUNT_WIDTH > CLIP_W) ? COUNT_WIDTH : CLIP_W;
  localparam int EXC_W  = H_W + 8;
  localparam int CUM_W  = H_W + 9;
  localparam int NUM_W  = CUM_W + 8;
  localparam int AREA_W = 2 * TW_W;
  localparam int REM_W  = AREA_W + 8;

  // request queue, depth a power of two
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // function codes
  localparam logic [1:0] FUNC_COUNT = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_MAP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_PIXELS = 3'd4;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_BUILD,
    OP_MAP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PIX_W-1:0]  pix;
    logic [TILE_W-1:0] tile;
  } job_t;

  // effective configuration, zero sizes and grid clamped
  typedef struct packed {
    logic [TW_W-1:0]   tw;
    logic [TW_W-1:0]   th;
    logic [GCNT_W-1:0] gc;
    logic [GCNT_W-1:0] gr;
    logic [CLIP_W-1:0] clip;
    logic [AREA_W-1:0] area;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_MAP_RD,
    ST_MAP_OUT,
    ST_EXC_RD,
    ST_EXC_ACC,
    ST_CUM_RD,
    ST_CUM_ADD,
    ST_DIV_INIT,
    ST_DIV,
    ST_MAP_WR
  } bstate_t;

endpackage
`default_nettype wire

// File: design/thist_fifo.sv
`default_nettype none
module thist_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  thist_pkg::job_t    push_job,
  output logic               full,
  input  wire                pop,
  output thist_pkg::job_t    head_job,
  output logic               empty
);
  import thist_pkg::*;

  job_t              mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_r, wptr_nxt;
  logic [FPTR_W-1:0] rptr_r, rptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rptr_r];

  // pointer and fill update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !full) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// File: design/thist_front.sv
`default_nettype none
module thist_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  thist_pkg::cfg_t                     cfg,
  input  wire                                 clearing,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [1:0]                          in_func,
  input  wire  [thist_pkg::PIX_W-1:0]         in_pixel_value,
  input  wire  [thist_pkg::COORD_WIDTH-1:0]   in_column,
  input  wire  [thist_pkg::COORD_WIDTH-1:0]   in_row,
  output logic                                push,
  output thist_pkg::job_t                     push_job,
  input  wire                                 fifo_full
);
  import thist_pkg::*;

  localparam int PROD_W = ((TW_W + GCNT_W) > COORD_WIDTH) ? (TW_W + GCNT_W) : COORD_WIDTH;

  // number of whole tiles before a coordinate, saturating at GRID_MAX
  function automatic logic [GCNT_W-1:0] tile_pos(input logic [COORD_WIDTH-1:0] c,
                                                 input logic [TW_W-1:0] t);
    logic [GCNT_W-1:0] n;
    logic [PROD_W-1:0] m;
    n = '0;
    for (int k = 1; k <= GRID_MAX; k++) begin
      m = PROD_W'(k) * PROD_W'(t);
      if (PROD_W'(c) >= m) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

  logic                   stg_v_r, stg_v_nxt;
  logic [1:0]             stg_func_r;
  logic [PIX_W-1:0]       stg_pix_r;
  logic [COORD_WIDTH-1:0] stg_col_r;
  logic [COORD_WIDTH-1:0] stg_row_r;

  logic [GCNT_W-1:0] tx, ty, tx_c, ty_c;
  logic              in_grid, drop, go, accept;
  op_t               op;

  // tile position of the staged request
  assign tx      = tile_pos(stg_col_r, cfg.tw);
  assign ty      = tile_pos(stg_row_r, cfg.th);
  assign in_grid = (tx < cfg.gc) && (ty < cfg.gr);
  assign tx_c    = (tx >= cfg.gc) ? cfg.gc - 1'b1 : tx;
  assign ty_c    = (ty >= cfg.gr) ? cfg.gr - 1'b1 : ty;

  // classify
  always_comb begin
    op   = OP_COUNT;
    drop = 1'b0;
    unique case (stg_func_r)
      FUNC_COUNT: begin
        op   = OP_COUNT;
        drop = !in_grid;
      end
      FUNC_BUILD: op = OP_BUILD;
      FUNC_MAP:   op = OP_MAP;
      default:    drop = 1'b1;
    endcase
  end

  assign push_job.op   = op;
  assign push_job.pix  = stg_pix_r;
  assign push_job.tile = TILE_W'(ty_c) * TILE_W'(GRID_MAX) + TILE_W'(tx_c);

  // staging handshake
  assign go     = stg_v_r && (drop || !fifo_full);
  assign push   = stg_v_r && !drop && !fifo_full;
  assign busy   = clearing || (stg_v_r && !go);
  assign accept = start && !busy;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (accept) begin
      stg_v_nxt = 1'b1;
    end else if (go) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_func_r <= in_func;
      stg_pix_r  <= in_pixel_value;
      stg_col_r  <= in_column;
      stg_row_r  <= in_row;
    end
  end

endmodule
`default_nettype wire

// File: design/thist_back.sv
`default_nettype none
module thist_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  thist_pkg::cfg_t               cfg,
  input  thist_pkg::job_t               head_job,
  input  wire                           fifo_empty,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  output logic [thist_pkg::PIX_W-1:0]   out_value,
  output logic                          out_tables_ready
);
  import thist_pkg::*;

  // histogram bins and mapping tables
  logic [COUNT_WIDTH-1:0] bin_mem [NENTRIES];
  logic [PIX_W-1:0]       map_mem [NENTRIES];

  logic                   bin_we;
  logic [ADDR_W-1:0]      bin_wa, bin_ra;
  logic [COUNT_WIDTH-1:0] bin_wd, bin_q_r;
  logic                   map_we;
  logic [ADDR_W-1:0]      map_wa, map_ra;
  logic [PIX_W-1:0]       map_wd, map_q_r;

  bstate_t           state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [PIX_W-1:0]  bin_r, bin_nxt;
  logic [POS_W-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [EXC_W-1:0]  exc_r, exc_nxt;
  logic [CUM_W-1:0]  cum_r, cum_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [PIX_W-1:0]  q_r, q_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_value_r, out_value_nxt;
  logic              out_ready_r, out_ready_nxt;

  logic [TILE_W-1:0] btile;
  logic [ADDR_W-1:0] baddr, jaddr;
  logic [H_W-1:0]    hq, clipv, hc;
  logic [NUM_W-1:0]  num, lim;
  logic              bin_last, tile_in_grid, ge;

  assign btile        = TILE_W'(by_r) * TILE_W'(GRID_MAX) + TILE_W'(bx_r);
  assign baddr        = {btile, bin_r};
  assign jaddr        = {job_r.tile, job_r.pix};
  assign hq           = H_W'(bin_q_r);
  assign clipv        = H_W'(cfg.clip);
  assign hc           = (hq > clipv) ? clipv : hq;
  assign num          = (NUM_W'(cum_r) << 8) - NUM_W'(cum_r);
  assign lim          = NUM_W'(cfg.area) << 8;
  assign bin_last     = (bin_r == '1);
  assign tile_in_grid = (GCNT_W'(bx_r) < cfg.gc) && (GCNT_W'(by_r) < cfg.gr);
  assign ge           = (rem_r >= dsr_r);

  assign clearing         = (state_r == ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_tables_ready = out_ready_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    clr_nxt       = clr_r;
    bin_nxt       = bin_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    exc_nxt       = exc_r;
    cum_nxt       = cum_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_ready_nxt = out_ready_r;
    pop           = 1'b0;
    bin_we        = 1'b0;
    bin_wa        = baddr;
    bin_wd        = '0;
    bin_ra        = baddr;
    map_we        = 1'b0;
    map_wa        = baddr;
    map_wd        = q_r;
    map_ra        = jaddr;
    unique case (state_r)
      ST_CLEAR: begin
        bin_we  = 1'b1;
        bin_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(NENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          job_nxt = head_job;
          unique case (head_job.op)
            OP_COUNT: state_nxt = ST_CNT_RD;
            OP_MAP:   state_nxt = ST_MAP_RD;
            OP_BUILD: begin
              state_nxt = ST_EXC_RD;
              bin_nxt   = '0;
              bx_nxt    = '0;
              by_nxt    = '0;
              exc_nxt   = '0;
              cum_nxt   = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD: begin
        bin_ra    = jaddr;
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        // saturating increment
        bin_wa    = jaddr;
        bin_wd    = bin_q_r + 1'b1;
        bin_we    = (bin_q_r != '1);
        state_nxt = ST_IDLE;
      end
      ST_MAP_RD: begin
        state_nxt = ST_MAP_OUT;
      end
      ST_MAP_OUT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = map_q_r;
        out_ready_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_EXC_RD: begin
        state_nxt = ST_EXC_ACC;
      end
      ST_EXC_ACC: begin
        // sum of counts above the clip level
        if (hq > clipv) begin
          exc_nxt = exc_r + EXC_W'(hq - clipv);
        end
        bin_nxt   = bin_r + 1'b1;
        state_nxt = bin_last ? ST_CUM_RD : ST_EXC_RD;
      end
      ST_CUM_RD: begin
        state_nxt = ST_CUM_ADD;
      end
      ST_CUM_ADD: begin
        // clipped count plus redistributed share, bin cleared behind
        cum_nxt   = cum_r + CUM_W'(hc) + CUM_W'(exc_r[EXC_W-1:8]);
        bin_we    = 1'b1;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        if (num >= lim) begin
          q_nxt     = '1;
          state_nxt = ST_MAP_WR;
        end else begin
          rem_nxt   = REM_W'(num);
          dsr_nxt   = REM_W'(cfg.area) << 7;
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (ge) begin
          rem_nxt = rem_r - dsr_r;
        end
        q_nxt    = {q_r[PIX_W-2:0], ge};
        dsr_nxt  = dsr_r >> 1;
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd7) begin
          state_nxt = ST_MAP_WR;
        end
      end
      ST_MAP_WR: begin
        map_we    = tile_in_grid;
        bin_nxt   = bin_r + 1'b1;
        state_nxt = ST_CUM_RD;
        if (bin_last) begin
          exc_nxt   = '0;
          cum_nxt   = '0;
          state_nxt = ST_EXC_RD;
          if (bx_r == POS_W'(GRID_MAX - 1)) begin
            bx_nxt = '0;
            if (by_r == POS_W'(GRID_MAX - 1)) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_ready_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              by_nxt = by_r + 1'b1;
            end
          end else begin
            bx_nxt = bx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    bin_r       <= bin_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    exc_r       <= exc_nxt;
    cum_r       <= cum_nxt;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    q_r         <= q_nxt;
    step_r      <= step_nxt;
    out_value_r <= out_value_nxt;
    out_ready_r <= out_ready_nxt;
  end

  // bin memory
  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
    bin_q_r <= bin_mem[bin_ra];
  end

  // mapping table memory
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q_r <= map_mem[map_ra];
  end

endmodule
`default_nettype wire

// File: design/tile_histogram_equalizer_top.sv
`default_nettype none
// Tiled histogram equalizer for 8-bit lightness pixels.
// Requests enter on start while busy is low, with in_func selecting: count
// (add the pixel to its tile histogram), build (make all mapping tables and
// clear the histograms) or map (look the pixel up in its tile's table).
// Count requests give no result; build and map give one result, shown for a
// single cycle with out_valid. The receiver cannot hold results off.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, which the block itself does not enforce.
// The back end reads and writes back the bin memory for a count request and
// reads the mapping table for a map request; a two-entry queue lets the
// front stage keep accepting meanwhile, until the queue fills.
// A build walks all GRID_MAX*GRID_MAX tiles: per tile it reads every bin to
// sum the excess, then per bin reads it again, accumulates, runs an 8-step
// divider (skipped when the value saturates) and writes the table.
// After reset the bin memory is zeroed, one entry a cycle, all 16384 entries,
// with busy high; configuration writes are taken throughout.
module tile_histogram_equalizer_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [1:0]                         in_func,
  input  wire  [thist_pkg::PIX_W-1:0]        in_pixel_value,
  input  wire  [thist_pkg::COORD_WIDTH-1:0]  in_column,
  input  wire  [thist_pkg::COORD_WIDTH-1:0]  in_row,
  output logic                               out_valid,
  output logic [thist_pkg::PIX_W-1:0]        out_value,
  output logic                               out_tables_ready,
  input  wire                                cfg_we,
  input  wire  [thist_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [thist_pkg::CFG_W-1:0]        cfg_wdata
);
  import thist_pkg::*;

  `include "assert_macros.svh"

  logic [TW_W-1:0]   tw_r, th_r;
  logic [GC_W-1:0]   gc_r, gr_r;
  logic [CLIP_W-1:0] clip_r;
  logic [AREA_W-1:0] area_r;
  logic [TW_W-1:0]   tw_e, th_e;
  logic [GCNT_W-1:0] gc_e, gr_e;
  cfg_t              cfg;

  logic clearing, push, pop, fifo_full, fifo_empty;
  job_t push_job, head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r   <= TW_W'(64);
      th_r   <= TW_W'(64);
      gc_r   <= GC_W'(8);
      gr_r   <= GC_W'(8);
      clip_r <= CLIP_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_WIDTH:  tw_r   <= cfg_wdata[TW_W-1:0];
        CFG_TILE_HEIGHT: th_r   <= cfg_wdata[TW_W-1:0];
        CFG_GRID_COLS:   gc_r   <= cfg_wdata[GC_W-1:0];
        CFG_GRID_ROWS:   gr_r   <= cfg_wdata[GC_W-1:0];
        CFG_CLIP_PIXELS: clip_r <= cfg_wdata[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero sizes act as one, grid clamped to its range
  assign tw_e = (tw_r == '0) ? TW_W'(1) : tw_r;
  assign th_e = (th_r == '0) ? TW_W'(1) : th_r;
  assign gc_e = (gc_r == '0) ? GCNT_W'(1) :
                (int'(gc_r) > GRID_MAX) ? GCNT_W'(GRID_MAX) : GCNT_W'(gc_r);
  assign gr_e = (gr_r == '0) ? GCNT_W'(1) :
                (int'(gr_r) > GRID_MAX) ? GCNT_W'(GRID_MAX) : GCNT_W'(gr_r);

  // tile area
  always_ff @(posedge clk) begin
    area_r <= AREA_W'(tw_e) * AREA_W'(th_e);
  end

  assign cfg.tw   = tw_e;
  assign cfg.th   = th_e;
  assign cfg.gc   = gc_e;
  assign cfg.gr   = gr_e;
  assign cfg.clip = clip_r;
  assign cfg.area = area_r;

  thist_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .clearing       (clearing),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_pixel_value (in_pixel_value),
    .in_column      (in_column),
    .in_row         (in_row),
    .push           (push),
    .push_job       (push_job),
    .fifo_full      (fifo_full)
  );

  thist_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (fifo_empty)
  );

  thist_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head_job         (head_job),
    .fifo_empty       (fifo_empty),
    .pop              (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_tables_ready (out_tables_ready)
  );

  // checks
  `THIST_ASSERT_SAME(a_busy_in_clear, clearing, busy)
  `THIST_ASSERT_SAME(a_quiet_in_clear, clearing, !out_valid)
  `THIST_ASSERT_SAME(a_build_value_zero, out_valid && out_tables_ready, out_value == '0)
  `THIST_ASSERT_NEXT(a_single_result, out_valid, !out_valid)

endmodule
`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
  import thist_pkg::*;

  typedef struct {
    logic [1:0]             func;
    logic [PIX_W-1:0]       pix;
    logic [COORD_WIDTH-1:0] col;
    logic [COORD_WIDTH-1:0] row;
  } pixel_req_t;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             ready;
  } eq_result_t;

  localparam int WATCHDOG_LIMIT = 1000000;

  // function code with no meaning, ignored by the block
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_func;
  logic [PIX_W-1:0]       in_pixel_value;
  logic [COORD_WIDTH-1:0] in_column;
  logic [COORD_WIDTH-1:0] in_row;
  logic                   out_valid;
  logic [PIX_W-1:0]       out_value;
  logic                   out_tables_ready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  pixel_req_t pending_reqs[$];
  eq_result_t expected_pixels[$];

  // shadow of the block state
  int unsigned    hist_bins[NENTRIES];
  logic [7:0]     eq_tables[NENTRIES];
  int unsigned    sh_tw, sh_th, sh_gc, sh_gr, sh_clip;

  int  fail_count;
  int  idle_pct;
  int  cyc_count;
  int  quiet_cycles;

  tile_histogram_equalizer_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pixel_value(in_pixel_value),
    .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_value(out_value),
    .out_tables_ready(out_tables_ready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned grid_clamp(int unsigned v);
    if (v == 0) return 1;
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  // clip, redistribute, accumulate and scale every tile of the grid, then clear all bins
  function automatic void build_eq_tables();
    int unsigned tw, th, gc, gr, base;
    longint unsigned excess, add, cum, h, scaled, area;
    tw = (sh_tw == 0) ? 1 : sh_tw;
    th = (sh_th == 0) ? 1 : sh_th;
    gc = grid_clamp(sh_gc);
    gr = grid_clamp(sh_gr);
    area = longint'(tw) * th;
    for (int y = 0; y < gr; y++) begin
      for (int x = 0; x < gc; x++) begin
        base = (y * GRID_MAX + x) * NBINS;
        excess = 0;
        for (int i = 0; i < NBINS; i++)
          if (hist_bins[base + i] > sh_clip) excess += hist_bins[base + i] - sh_clip;
        add = excess / NBINS;
        cum = 0;
        for (int i = 0; i < NBINS; i++) begin
          h = hist_bins[base + i];
          if (h > sh_clip) h = sh_clip;
          cum += h + add;
          scaled = (cum * 255) / area;
          eq_tables[base + i] = (scaled > 255) ? 8'd255 : scaled[7:0];
        end
      end
    end
    foreach (hist_bins[i]) hist_bins[i] = 0;
  endfunction

  // advance the shadow state for one accepted request
  function automatic void predict_request(pixel_req_t r);
    int unsigned tw, th, gc, gr, tx, ty, idx;
    eq_result_t res;
    tw = (sh_tw == 0) ? 1 : sh_tw;
    th = (sh_th == 0) ? 1 : sh_th;
    gc = grid_clamp(sh_gc);
    gr = grid_clamp(sh_gr);
    tx = r.col / tw;
    ty = r.row / th;
    case (r.func)
      FUNC_COUNT: begin
        if (tx < gc && ty < gr) begin
          idx = (ty * GRID_MAX + tx) * NBINS + r.pix;
          if (hist_bins[idx] < 24'hFFFFFF) hist_bins[idx]++;
        end
      end
      FUNC_BUILD: begin
        build_eq_tables();
        res.value = '0;
        res.ready = 1'b1;
        expected_pixels.push_back(res);
      end
      FUNC_MAP: begin
        if (tx > gc - 1) tx = gc - 1;
        if (ty > gr - 1) ty = gr - 1;
        res.value = eq_tables[(ty * GRID_MAX + tx) * NBINS + r.pix];
        res.ready = 1'b0;
        expected_pixels.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // driver: next request presented once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      cyc_count <= cyc_count + 1;
      case ((cyc_count / 200) % 4)
        0: idle_pct = 0;
        1: idle_pct = 75;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start          <= 1'b1;
          in_func        <= pending_reqs[0].func;
          in_pixel_value <= pending_reqs[0].pix;
          in_column      <= pending_reqs[0].col;
          in_row         <= pending_reqs[0].row;
          void'(pending_reqs.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on acceptance, check each result
  always @(posedge clk) begin
    pixel_req_t r;
    eq_result_t e;
    if (rst_n) begin
      if (start && !busy) begin
        r.func = in_func;
        r.pix  = in_pixel_value;
        r.col  = in_column;
        r.row  = in_row;
        predict_request(r);
      end
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result value=%0d tables_ready=%0b",
                 out_value, out_tables_ready);
          fail_count++;
        end else begin
          e = expected_pixels.pop_front();
          if (out_value !== e.value) begin
            $error("out_value expected %0d got %0d", e.value, out_value);
            fail_count++;
          end
          if (out_tables_ready !== e.ready) begin
            $error("tables_ready expected %0b got %0b", e.ready, out_tables_ready);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any request or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      CFG_TILE_WIDTH:  sh_tw   = val & 12'hFFF;
      CFG_TILE_HEIGHT: sh_th   = val & 12'hFFF;
      CFG_GRID_COLS:   sh_gc   = val & 4'hF;
      CFG_GRID_ROWS:   sh_gr   = val & 4'hF;
      CFG_CLIP_PIXELS: sh_clip = val & 24'hFFFFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_req(input logic [1:0] f, input int unsigned p,
                          input int unsigned c, input int unsigned r);
    pixel_req_t q;
    q.func = f;
    q.pix  = p;
    q.col  = c;
    q.row  = r;
    pending_reqs.push_back(q);
  endtask

  // wait until every request is taken and every result is in
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || start || busy || expected_pixels.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  // random mix of counts, maps and unknown codes, mostly inside the grid
  task automatic random_reqs(input int n, input int unsigned span_c,
                             input int unsigned span_r);
    int unsigned sel, c, r;
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      f = (sel < 60) ? FUNC_COUNT : (sel < 95) ? FUNC_MAP : FUNC_NONE;
      if ($urandom_range(9) < 8) begin
        c = $urandom_range(span_c);
        r = $urandom_range(span_r);
      end else begin
        c = $urandom & 12'hFFF;
        r = $urandom & 12'hFFF;
      end
      push_req(f, $urandom & 8'hFF, c, r);
    end
  endtask

  initial begin
    fail_count = 0;
    cyc_count = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_COUNT;
    in_pixel_value = '0;
    in_column = '0;
    in_row = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sh_tw = 64; sh_th = 64; sh_gc = 8; sh_gr = 8; sh_clip = 32;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    foreach (eq_tables[i]) eq_tables[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, pixels beyond the grid, unknown function, full build
    write_reg(CFG_CLIP_PIXELS, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) push_req(FUNC_COUNT, 0, 0, 0);
    push_req(FUNC_COUNT, 255, 511, 511);
    push_req(FUNC_COUNT, 255, 4095, 0);
    push_req(FUNC_COUNT, 0, 0, 4095);
    push_req(FUNC_COUNT, 128, 4095, 4095);
    push_req(FUNC_NONE, 255, 4095, 4095);
    push_req(FUNC_COUNT, 85, 2730, 1365);
    push_req(FUNC_COUNT, 170, 1365, 2730);
    push_req(FUNC_BUILD, 0, 0, 0);
    push_req(FUNC_MAP, 0, 0, 0);
    push_req(FUNC_MAP, 255, 0, 0);
    push_req(FUNC_MAP, 255, 511, 511);
    push_req(FUNC_MAP, 255, 4095, 4095);
    push_req(FUNC_MAP, 0, 4095, 0);
    push_req(FUNC_MAP, 128, 0, 4095);
    push_req(FUNC_NONE, 0, 0, 0);
    drain();

    // tiny tiles: table values saturate
    write_reg(CFG_TILE_WIDTH, 1);
    write_reg(CFG_TILE_HEIGHT, 1);
    write_reg(CFG_GRID_COLS, 5);
    write_reg(CFG_GRID_ROWS, 3);
    write_reg(CFG_CLIP_PIXELS, 1);
    random_reqs(800, 6, 4);
    push_req(FUNC_BUILD, 0, 0, 0);
    for (int i = 0; i < 30; i++)
      push_req(FUNC_MAP, $urandom & 8'hFF, $urandom_range(6), $urandom_range(4));
    drain();

    // zero width, tallest tile, grid beyond limits, no clip headroom
    write_reg(CFG_TILE_WIDTH, 0);
    write_reg(CFG_TILE_HEIGHT, 4095);
    write_reg(CFG_GRID_COLS, 15);
    write_reg(CFG_GRID_ROWS, 0);
    write_reg(CFG_CLIP_PIXELS, 0);
    random_reqs(800, 12, 4095);
    push_req(FUNC_BUILD, 0, 0, 0);
    for (int i = 0; i < 30; i++)
      push_req(FUNC_MAP, $urandom & 8'hFF, $urandom & 12'hFFF, $urandom & 12'hFFF);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
